[rtl/core/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, widths and codes for the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY    = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int DATA_W      = 32;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = ((DATA_W + STATUS_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_TDATA_W - DATA_W - STATUS_W;

  localparam logic [CNT_W-1:0] CNT_ZERO = '0;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);

  // operation kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ALL    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LEFT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // pointer update
  localparam logic [2:0] PTR_HOLD = 3'd0;
  localparam logic [2:0] PTR_ZERO = 3'd1;
  localparam logic [2:0] PTR_INC  = 3'd2;
  localparam logic [2:0] PTR_DEC  = 3'd3;
  localparam logic [2:0] PTR_CNT  = 3'd4;

  // found-position update
  localparam logic [1:0] POS_HOLD = 2'd0;
  localparam logic [1:0] POS_PTR  = 2'd1;
  localparam logic [1:0] POS_CNT  = 2'd2;
  localparam logic [1:0] POS_ZERO = 2'd3;

  // memory read address source
  localparam logic [1:0] ADDR_PTR  = 2'd0;
  localparam logic [1:0] ADDR_NEXT = 2'd1;
  localparam logic [1:0] ADDR_PREV = 2'd2;

  typedef struct packed {
    logic                key_ld;
    logic [2:0]          ptr_op;
    logic [1:0]          pos_op;
    logic                n_clr;
    logic                n_inc;
    logic                rd_en;
    logic [1:0]          addr_sel;
    logic                wr_en;
    logic                wr_key;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                out_ld;
    logic                out_zero;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } sle_cmd_t;

  typedef struct packed {
    logic             cnt_zero;
    logic             cnt_full;
    logic             hit_le;
    logic             hit_eq;
    logic             ptr_last;
    logic             ptr_at_pos;
    logic             n_last;
    logic             out_free;
    logic [CNT_W-1:0] cnt;
  } sle_stat_t;

endpackage

[rtl/core/sle_ram.sv]
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                           clk,
  input  logic                                           wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]                               wr_data,
  input  logic                                           rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
  output logic [WIDTH-1:0]                               rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/sle_dp.sv]
// ----------------------------------------------------------------------------
// sle_dp
// Datapath: entry store, count, pointers, key compare and result register.
// ----------------------------------------------------------------------------
module sle_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [sle_pkg::DATA_W-1:0]      in_value,
  input  sle_pkg::sle_cmd_t               cmd,
  output sle_pkg::sle_stat_t              st,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [sle_pkg::DATA_W-1:0]      out_item,
  output logic [sle_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_last
);

  logic [sle_pkg::DATA_W-1:0] key;
  logic [sle_pkg::CNT_W-1:0]  count;
  logic [sle_pkg::CNT_W-1:0]  ptr;
  logic [sle_pkg::CNT_W-1:0]  pos;
  logic [sle_pkg::CNT_W-1:0]  n;
  logic [sle_pkg::CNT_W-1:0]  ptr_nxt;
  logic [sle_pkg::CNT_W-1:0]  ptr_prv;
  logic [sle_pkg::CNT_W-1:0]  rd_ptr;
  logic [sle_pkg::DATA_W-1:0] rd_data;
  logic [sle_pkg::DATA_W-1:0] wr_data;

  // circular neighbours over the live part of the store
  assign ptr_nxt = (ptr + sle_pkg::CNT_ONE == count) ? sle_pkg::CNT_ZERO
                                                     : ptr + sle_pkg::CNT_ONE;
  assign ptr_prv = (ptr == sle_pkg::CNT_ZERO) ? count - sle_pkg::CNT_ONE
                                              : ptr - sle_pkg::CNT_ONE;

  always_comb begin
    case (cmd.addr_sel)
      sle_pkg::ADDR_NEXT: rd_ptr = ptr_nxt;
      sle_pkg::ADDR_PREV: rd_ptr = ptr_prv;
      default:            rd_ptr = ptr;
    endcase
  end

  assign wr_data = cmd.wr_key ? key : rd_data;

  sle_ram #(
    .WIDTH (sle_pkg::DATA_W),
    .DEPTH (sle_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (ptr[sle_pkg::IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_ptr[sle_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.key_ld) begin
      key <= in_value;
    end
    case (cmd.ptr_op)
      sle_pkg::PTR_ZERO: ptr <= sle_pkg::CNT_ZERO;
      sle_pkg::PTR_INC:  ptr <= ptr_nxt;
      sle_pkg::PTR_DEC:  ptr <= ptr_prv;
      sle_pkg::PTR_CNT:  ptr <= count;
      default:           ptr <= ptr;
    endcase
    case (cmd.pos_op)
      sle_pkg::POS_PTR:  pos <= ptr;
      sle_pkg::POS_CNT:  pos <= count;
      sle_pkg::POS_ZERO: pos <= sle_pkg::CNT_ZERO;
      default:           pos <= pos;
    endcase
    if (cmd.n_clr) begin
      n <= sle_pkg::CNT_ZERO;
    end else if (cmd.n_inc) begin
      n <= n + sle_pkg::CNT_ONE;
    end
    if (cmd.out_ld) begin
      out_item   <= cmd.out_zero ? '0 : rd_data;
      out_status <= cmd.out_status;
      out_last   <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= sle_pkg::CNT_ZERO;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + sle_pkg::CNT_ONE;
      end else if (cmd.cnt_dec) begin
        count <= count - sle_pkg::CNT_ONE;
      end
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.cnt_zero   = (count == sle_pkg::CNT_ZERO);
  assign st.cnt_full   = (count >= sle_pkg::CNT_CAP);
  assign st.hit_le     = ($signed(rd_data) <= $signed(key));
  assign st.hit_eq     = (rd_data == key);
  assign st.ptr_last   = (ptr + sle_pkg::CNT_ONE == count);
  assign st.ptr_at_pos = (ptr == pos);
  assign st.n_last     = (n + sle_pkg::CNT_ONE == count);
  assign st.out_free   = !out_valid || out_ready;
  assign st.cnt        = count;

endmodule

[rtl/core/sle_ctrl.sv]
// ----------------------------------------------------------------------------
// sle_ctrl
// Controller: sequences scans, shifts and emits over the datapath.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [sle_pkg::KIND_W-1:0]    in_kind,
  output logic                          in_ready,
  input  sle_pkg::sle_stat_t            st,
  output sle_pkg::sle_cmd_t             cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN_RD = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_INS_SH  = 4'd3;
  localparam logic [3:0] S_INS_WR  = 4'd4;
  localparam logic [3:0] S_DEL_RD  = 4'd5;
  localparam logic [3:0] S_DEL_WR  = 4'd6;
  localparam logic [3:0] S_EMIT_RD = 4'd7;
  localparam logic [3:0] S_EMIT_LD = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  logic [3:0]                     state;
  logic [3:0]                     state_next;
  logic [sle_pkg::KIND_W-1:0]     kind;
  logic [sle_pkg::KIND_W-1:0]     kind_next;
  logic [sle_pkg::STATUS_W-1:0]   resp;
  logic [sle_pkg::STATUS_W-1:0]   resp_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    kind_next  = kind;
    resp_next  = resp;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.key_ld = 1'b1;
          cmd.n_clr  = 1'b1;
          kind_next  = in_kind;
          case (in_kind)
            sle_pkg::KIND_INSERT: begin
              if (st.cnt_full) begin
                resp_next  = sle_pkg::ST_FULL;
                state_next = S_RESP;
              end else if (st.cnt_zero) begin
                cmd.ptr_op = sle_pkg::PTR_ZERO;
                cmd.pos_op = sle_pkg::POS_ZERO;
                state_next = S_INS_SH;
              end else begin
                cmd.ptr_op = sle_pkg::PTR_ZERO;
                state_next = S_SCAN_RD;
              end
            end
            sle_pkg::KIND_DELETE, sle_pkg::KIND_LEFT, sle_pkg::KIND_RIGHT: begin
              if (st.cnt_zero) begin
                resp_next  = sle_pkg::ST_EMPTY;
                state_next = S_RESP;
              end else begin
                cmd.ptr_op = sle_pkg::PTR_ZERO;
                state_next = S_SCAN_RD;
              end
            end
            sle_pkg::KIND_ALL: begin
              if (st.cnt_zero) begin
                resp_next  = sle_pkg::ST_EMPTY;
                state_next = S_RESP;
              end else begin
                cmd.ptr_op = sle_pkg::PTR_ZERO;
                state_next = S_EMIT_RD;
              end
            end
            default: ;  // unused kinds are dropped
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        // read data holds the entry at ptr
        if (kind == sle_pkg::KIND_INSERT) begin
          if (st.hit_le) begin
            cmd.pos_op = sle_pkg::POS_PTR;
            cmd.ptr_op = sle_pkg::PTR_CNT;
            state_next = S_INS_SH;
          end else if (st.ptr_last) begin
            cmd.pos_op = sle_pkg::POS_CNT;
            cmd.ptr_op = sle_pkg::PTR_CNT;
            state_next = S_INS_SH;
          end else begin
            cmd.ptr_op   = sle_pkg::PTR_INC;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = sle_pkg::ADDR_NEXT;
          end
        end else begin
          if (st.hit_eq) begin
            state_next = (kind == sle_pkg::KIND_DELETE) ? S_DEL_RD : S_EMIT_LD;
          end else if (st.ptr_last) begin
            resp_next  = sle_pkg::ST_NOTFOUND;
            state_next = S_RESP;
          end else begin
            cmd.ptr_op   = sle_pkg::PTR_INC;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = sle_pkg::ADDR_NEXT;
          end
        end
      end
      S_INS_SH: begin
        if (st.ptr_at_pos) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          resp_next   = sle_pkg::ST_OK;
          state_next  = S_RESP;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = sle_pkg::ADDR_PREV;
          state_next   = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.ptr_op = sle_pkg::PTR_DEC;
        state_next = S_INS_SH;
      end
      S_DEL_RD: begin
        if (st.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          resp_next   = sle_pkg::ST_OK;
          state_next  = S_RESP;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = sle_pkg::ADDR_NEXT;
          state_next   = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.ptr_op = sle_pkg::PTR_INC;
        state_next = S_DEL_RD;
      end
      S_EMIT_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (st.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = sle_pkg::ST_OK;
          cmd.out_last   = st.n_last;
          if (st.n_last) begin
            state_next = S_IDLE;
          end else begin
            // fetch the next word while this one goes out
            cmd.n_inc = 1'b1;
            cmd.rd_en = 1'b1;
            if (kind == sle_pkg::KIND_LEFT) begin
              cmd.ptr_op   = sle_pkg::PTR_DEC;
              cmd.addr_sel = sle_pkg::ADDR_PREV;
            end else begin
              cmd.ptr_op   = sle_pkg::PTR_INC;
              cmd.addr_sel = sle_pkg::ADDR_NEXT;
            end
          end
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_zero   = 1'b1;
          cmd.out_status = resp;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    kind <= kind_next;
    resp <= resp_next;
  end

endmodule

[rtl/core/sorted_list_engine.sv]
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded list of signed words kept largest first, with insert, delete and
// full or circular reads from a key.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser     | tlast
//  s_axis   | in  | value[31:0]                    | kind[2:0] | -
//  m_axis   | out | item[31:0], status[33:32], pad | -         | last
//
//  One command at a time; s_axis_tready is high only when the controller is idle.
//  Insert and delete find their place, then move the entries behind it one
//  by one. Left and right reads scan for the key, full reads start at entry 0;
//  then one word per cycle while m_axis takes them, set by the single read port of
//  the entry RAM.
//  A stalled m_axis holds the pipeline. Reset empties the list at once.
// ----------------------------------------------------------------------------
module sorted_list_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sle_pkg::DATA_W-1:0]         s_axis_tdata,   // value
  input  logic [sle_pkg::KIND_W-1:0]         s_axis_tuser,   // kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sle_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // item, status, zero pad
  output logic                               m_axis_tlast
);

  sle_pkg::sle_cmd_t              cmd;
  sle_pkg::sle_stat_t             st;
  logic [sle_pkg::DATA_W-1:0]     out_item;
  logic [sle_pkg::STATUS_W-1:0]   out_status;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sle_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_value   (s_axis_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_item   (out_item),
    .out_status (out_status),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {{sle_pkg::PAD_W{1'b0}}, out_status, out_item};

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    st.cnt <= sle_pkg::CNT_CAP)
    else $error("entry count beyond capacity");

  a_no_ins_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !st.cnt_full)
    else $error("insert committed into a full list");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> st.out_free)
    else $error("result register overwritten before it was taken");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !cmd.wr_en && !cmd.cnt_dec)
    else $error("store modified while idle");
`endif

endmodule
